>>> design/cbpe_pkg.sv
package cbpe_pkg;

  localparam int STEP_W    = 10;
  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P0_X = 4'd0,
    REG_P0_Y = 4'd1,
    REG_P1_X = 4'd2,
    REG_P1_Y = 4'd3,
    REG_P2_X = 4'd4,
    REG_P2_Y = 4'd5,
    REG_P3_X = 4'd6,
    REG_P3_Y = 4'd7
  } cfg_idx_t;

  localparam int RST_P0_X = 200;
  localparam int RST_P0_Y = 300;
  localparam int RST_P1_X = 130;
  localparam int RST_P1_Y = 200;
  localparam int RST_P2_X = 110;
  localparam int RST_P2_Y = 100;
  localparam int RST_P3_X = 200;
  localparam int RST_P3_Y = 180;

endpackage

>>> design/cubic_bezier_point_eval.sv
// Cubic Bezier point evaluator. Four control points live in configuration
// registers (index 0..7: p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y);
// each input item carries a step index k and yields the curve point at
// t = k/STEPS, each coordinate truncated toward zero. A k above STEPS gives
// the end point. STEPS must be a power of two. The block takes one item per
// clock while the pipeline is not both full and stalled; four stages form
// the Bernstein weights, three multiply and sum them with the control
// coordinates, and a last stage takes the quotient by STEPS^3, which is a
// shift. A stalled output only holds the pipeline once every stage is
// occupied. Configuration writes are always accepted and must be made while
// no item is in flight.
module cubic_bezier_point_eval import cbpe_pkg::*; #(
  parameter int STEPS      = 1024,
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [STEP_W-1:0]     in_step_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_point_x,
  output logic [COORD_BITS-1:0] out_point_y,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int KW = $clog2(STEPS + 1);
  localparam int WW = 3 * KW;
  localparam int AW = WW + CB;
  localparam int L  = 8;

  logic [CB-1:0] p0_x_r, p0_y_r, p1_x_r, p1_y_r;
  logic [CB-1:0] p2_x_r, p2_y_r, p3_x_r, p3_y_r;
  logic [L-1:0]  stage_en;
  logic [WW-1:0] w0, w1, w2, w3;
  logic [AW-1:0] acc_x, acc_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_x_r <= CB'(RST_P0_X);
      p0_y_r <= CB'(RST_P0_Y);
      p1_x_r <= CB'(RST_P1_X);
      p1_y_r <= CB'(RST_P1_Y);
      p2_x_r <= CB'(RST_P2_X);
      p2_y_r <= CB'(RST_P2_Y);
      p3_x_r <= CB'(RST_P3_X);
      p3_y_r <= CB'(RST_P3_Y);
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_P0_X: p0_x_r <= cfg_data;
        REG_P0_Y: p0_y_r <= cfg_data;
        REG_P1_X: p1_x_r <= cfg_data;
        REG_P1_Y: p1_y_r <= cfg_data;
        REG_P2_X: p2_x_r <= cfg_data;
        REG_P2_Y: p2_y_r <= cfg_data;
        REG_P3_X: p3_x_r <= cfg_data;
        REG_P3_Y: p3_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cbpe_ctrl #(.L(L)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stage_en  (stage_en)
  );

  cbpe_weight #(.STEPS(STEPS), .KW(KW)) u_weight (
    .clk        (clk),
    .stage_en   (stage_en[3:0]),
    .step_index (in_step_index),
    .w0         (w0),
    .w1         (w1),
    .w2         (w2),
    .w3         (w3)
  );

  cbpe_blend #(.KW(KW), .CB(CB)) u_blend_x (
    .clk      (clk),
    .stage_en (stage_en[6:4]),
    .w0       (w0),
    .w1       (w1),
    .w2       (w2),
    .w3       (w3),
    .c0       (p0_x_r),
    .c1       (p1_x_r),
    .c2       (p2_x_r),
    .c3       (p3_x_r),
    .acc      (acc_x)
  );

  cbpe_blend #(.KW(KW), .CB(CB)) u_blend_y (
    .clk      (clk),
    .stage_en (stage_en[6:4]),
    .w0       (w0),
    .w1       (w1),
    .w2       (w2),
    .w3       (w3),
    .c0       (p0_y_r),
    .c1       (p1_y_r),
    .c2       (p2_y_r),
    .c3       (p3_y_r),
    .acc      (acc_y)
  );

  cbpe_div #(.STEPS(STEPS), .KW(KW), .CB(CB)) u_div_x (
    .clk      (clk),
    .stage_en (stage_en[L-1]),
    .acc_in   (acc_x),
    .quot     (out_point_x)
  );

  cbpe_div #(.STEPS(STEPS), .KW(KW), .CB(CB)) u_div_y (
    .clk      (clk),
    .stage_en (stage_en[L-1]),
    .acc_in   (acc_y),
    .quot     (out_point_y)
  );

endmodule

>>> design/cbpe_ctrl.sv
module cbpe_ctrl #(
  parameter int L = 17
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [L-1:0] stage_en
);

  logic [L-1:0] v_r;
  logic [L-1:0] empty;

  assign empty = ~v_r;

  // A stage may load when it or any later stage holds a bubble, or the output drains.
  always_comb begin
    for (int i = 0; i < L; i++) begin
      stage_en[i] = out_ready || ((empty >> i) != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (stage_en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < L; i++) begin
        if (stage_en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = v_r[L-1];

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pipeline not empty after reset");

  a_block_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v_r == '1 && !out_ready))
    else $error("input blocked while the pipeline has room");

  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(v_r) == $past($countones(v_r))
      + $past(int'(in_valid && in_ready)) - $past(int'(out_valid && out_ready)))
    else $error("item lost or duplicated in the pipeline");

  a_full_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r == '1 && !out_ready) |=> v_r == '1)
    else $error("stalled full pipeline dropped an item");

endmodule

>>> design/cbpe_weight.sv
module cbpe_weight import cbpe_pkg::*; #(
  parameter int STEPS = 1024,
  parameter int KW    = 11
) (
  input  logic              clk,
  input  logic [3:0]        stage_en,
  input  logic [STEP_W-1:0] step_index,
  output logic [3*KW-1:0]   w0,
  output logic [3*KW-1:0]   w1,
  output logic [3*KW-1:0]   w2,
  output logic [3*KW-1:0]   w3
);

  localparam int PW = 2 * KW;
  localparam int WW = 3 * KW;

  logic [KW-1:0] k_nxt, s_nxt;
  logic [KW-1:0] k1_r, s1_r;
  logic [KW-1:0] k2_r, s2_r;
  logic [PW-1:0] kk2_r, ss2_r;
  logic [WW-1:0] w0_3_r, t1_3_r, t2_3_r, w3_3_r;
  logic [WW-1:0] w0_r, w1_r, w2_r, w3_r;

  // Steps past the end of the curve clamp to the end point.
  always_comb begin
    if (32'(step_index) > STEPS) begin
      k_nxt = KW'(STEPS);
    end else begin
      k_nxt = KW'(step_index);
    end
    s_nxt = KW'(STEPS) - k_nxt;
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      k1_r <= k_nxt;
      s1_r <= s_nxt;
    end
    if (stage_en[1]) begin
      k2_r  <= k1_r;
      s2_r  <= s1_r;
      kk2_r <= PW'(k1_r) * PW'(k1_r);
      ss2_r <= PW'(s1_r) * PW'(s1_r);
    end
    if (stage_en[2]) begin
      w0_3_r <= WW'(ss2_r) * WW'(s2_r);
      t1_3_r <= WW'(ss2_r) * WW'(k2_r);
      t2_3_r <= WW'(kk2_r) * WW'(s2_r);
      w3_3_r <= WW'(kk2_r) * WW'(k2_r);
    end
    if (stage_en[3]) begin
      w0_r <= w0_3_r;
      w1_r <= t1_3_r + {t1_3_r[WW-2:0], 1'b0};
      w2_r <= t2_3_r + {t2_3_r[WW-2:0], 1'b0};
      w3_r <= w3_3_r;
    end
  end

  assign w0 = w0_r;
  assign w1 = w1_r;
  assign w2 = w2_r;
  assign w3 = w3_r;

endmodule

>>> design/cbpe_blend.sv
module cbpe_blend #(
  parameter int KW = 11,
  parameter int CB = 10
) (
  input  logic                 clk,
  input  logic [2:0]           stage_en,
  input  logic [3*KW-1:0]      w0,
  input  logic [3*KW-1:0]      w1,
  input  logic [3*KW-1:0]      w2,
  input  logic [3*KW-1:0]      w3,
  input  logic [CB-1:0]        c0,
  input  logic [CB-1:0]        c1,
  input  logic [CB-1:0]        c2,
  input  logic [CB-1:0]        c3,
  output logic [3*KW+CB-1:0]   acc
);

  localparam int AW = 3 * KW + CB;

  logic [AW-1:0] m0_r, m1_r, m2_r, m3_r;
  logic [AW-1:0] s01_r, s23_r;
  logic [AW-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      m0_r <= AW'(w0) * AW'(c0);
      m1_r <= AW'(w1) * AW'(c1);
      m2_r <= AW'(w2) * AW'(c2);
      m3_r <= AW'(w3) * AW'(c3);
    end
    if (stage_en[1]) begin
      s01_r <= m0_r + m1_r;
      s23_r <= m2_r + m3_r;
    end
    if (stage_en[2]) begin
      acc_r <= s01_r + s23_r;
    end
  end

  assign acc = acc_r;

endmodule

>>> design/cbpe_div.sv
module cbpe_div #(
  parameter int STEPS = 1024,
  parameter int KW    = 11,
  parameter int CB    = 10
) (
  input  logic               clk,
  input  logic               stage_en,
  input  logic [3*KW+CB-1:0] acc_in,
  output logic [CB-1:0]      quot
);

  // STEPS is a power of two, so the division by STEPS^3 is a shift.
  localparam int SH = 3 * $clog2(STEPS);

  logic [CB-1:0] q_r;

  always_ff @(posedge clk) begin
    if (stage_en) begin
      q_r <= acc_in[SH +: CB];
    end
  end

  assign quot = q_r;

endmodule

>>> test/testbench.sv
module testbench;
  import cbpe_pkg::*;

  localparam int COORD_W = 10;
  localparam longint unsigned CURVE_STEPS = 1024;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED = 4'd15;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [STEP_W-1:0] in_step_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COORD_W-1:0] out_point_x;
  logic [COORD_W-1:0] out_point_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;

  logic [COORD_W-1:0] ctrl_pt [8];
  logic [STEP_W-1:0] pending_steps [$];
  point_t curve_points_due [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit long_hold_request = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_left = 0;
  int mismatches = 0;

  cubic_bezier_point_eval #(
    .STEPS(1024),
    .COORD_BITS(COORD_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_step_index(in_step_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_point_x(out_point_x),
    .out_point_y(out_point_y),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [COORD_W-1:0] bernstein(input longint unsigned k,
                                                   input longint unsigned c0,
                                                   input longint unsigned c1,
                                                   input longint unsigned c2,
                                                   input longint unsigned c3);
    longint unsigned s;
    longint unsigned acc;
    s = CURVE_STEPS - k;
    acc = s * s * s * c0 + 3 * k * s * s * c1 + 3 * k * k * s * c2 + k * k * k * c3;
    return COORD_W'(acc / (CURVE_STEPS * CURVE_STEPS * CURVE_STEPS));
  endfunction

  function automatic point_t curve_point(input logic [STEP_W-1:0] step);
    longint unsigned k;
    point_t p;
    k = longint'(step);
    if (k > CURVE_STEPS) begin
      k = CURVE_STEPS;
    end
    p.x = bernstein(k, ctrl_pt[REG_P0_X], ctrl_pt[REG_P1_X], ctrl_pt[REG_P2_X],
                    ctrl_pt[REG_P3_X]);
    p.y = bernstein(k, ctrl_pt[REG_P0_Y], ctrl_pt[REG_P1_Y], ctrl_pt[REG_P2_Y],
                    ctrl_pt[REG_P3_Y]);
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        curve_points_due.push_back(curve_point(in_step_index));
      end
      if (!in_valid || in_ready) begin
        if (pending_steps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_step_index <= pending_steps.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (long_hold_request && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid && out_ready) begin
      if (curve_points_due.size() == 0) begin
        $error("unexpected item: point_x %0d point_y %0d", out_point_x, out_point_y);
        mismatches++;
      end else begin
        want = curve_points_due.pop_front();
        if (out_point_x !== want.x) begin
          $error("point_x: expected %0d, actual %0d", want.x, out_point_x);
          mismatches++;
        end
        if (out_point_y !== want.y) begin
          $error("point_y: expected %0d, actual %0d", want.y, out_point_y);
          mismatches++;
        end
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_P3_Y) begin
      ctrl_pt[idx[2:0]] = val;
    end
  endtask

  task automatic load_curve(input logic [7:0][COORD_W-1:0] pts);
    for (int i = REG_P0_X; i <= REG_P3_Y; i++) begin
      cfg_write(CFG_IDX_W'(i), pts[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic load_random_curve();
    logic [7:0][COORD_W-1:0] pts;
    for (int i = 0; i < 8; i++) begin
      pts[i] = COORD_W'($urandom_range(1023));
    end
    load_curve(pts);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_steps.size() != 0 || in_valid || curve_points_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_steps(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0: pending_steps.push_back('0);
        1: pending_steps.push_back('1);
        default: pending_steps.push_back(STEP_W'($urandom_range(1023)));
      endcase
    end
  endtask

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [7:0][COORD_W-1:0] mixed;
    ctrl_pt[REG_P0_X] = COORD_W'(RST_P0_X);
    ctrl_pt[REG_P0_Y] = COORD_W'(RST_P0_Y);
    ctrl_pt[REG_P1_X] = COORD_W'(RST_P1_X);
    ctrl_pt[REG_P1_Y] = COORD_W'(RST_P1_Y);
    ctrl_pt[REG_P2_X] = COORD_W'(RST_P2_X);
    ctrl_pt[REG_P2_Y] = COORD_W'(RST_P2_Y);
    ctrl_pt[REG_P3_X] = COORD_W'(RST_P3_X);
    ctrl_pt[REG_P3_Y] = COORD_W'(RST_P3_Y);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 10;
    recv_idle_pct = 74;
    // The reset curve is checked before any register is touched.
    pending_steps = {10'd0, 10'd1, 10'd2, 10'd511, 10'd512, 10'd513, 10'd1022,
                     10'd1023, 10'h155, 10'h2AA};
    wait_drained();

    load_curve('1);
    pending_steps = {10'd0, 10'd1, 10'd512, 10'd1023, 10'h155};
    wait_drained();

    load_curve('0);
    // Writes to indexes past the last register must leave the curve alone.
    for (int i = REG_FIRST_UNUSED; i <= REG_LAST_UNUSED; i++) begin
      cfg_write(CFG_IDX_W'(i), COORD_W'($urandom_range(1023)));
    end
    cfg_valid <= 1'b0;
    pending_steps = {10'd0, 10'd512, 10'd1023};
    wait_drained();

    for (int i = 0; i < 8; i++) begin
      mixed[i] = (i % 2 == 0) ? '0 : '1;
    end
    load_curve(mixed);
    cfg_write(REG_FIRST_UNUSED, '1);
    cfg_valid <= 1'b0;
    pending_steps = {10'd0, 10'd1, 10'd512, 10'd1023};
    wait_drained();

    load_random_curve();
    queue_random_steps(260);
    wait_drained();

    send_idle_pct = 74;
    recv_idle_pct = 10;
    load_random_curve();
    queue_random_steps(270);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_curve(~mixed);
    queue_random_steps(40);
    wait_drained();

    load_random_curve();
    queue_random_steps(230);
    long_hold_request = 1'b1;
    wait_drained();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
